@@ rtl/kuf_pkg.sv @@
`timescale 1ns / 1ps

package kuf_pkg;

	localparam int NODE_W   = 8;
	localparam int WEIGHT_W = 16;
	localparam int TOTAL_W  = 26;
	localparam int RANK_W   = 4;
	localparam int EPOCH_W  = 8;

	localparam logic [RANK_W-1:0]  RANK_MAX  = 4'd15;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 26'h3FF_FFFF;
	localparam logic [EPOCH_W-1:0] EPOCH_MAX = 8'hFF;
	localparam logic [EPOCH_W-1:0] EPOCH_ONE = 8'h01;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_ISSUE,
		ST_FIND,
		ST_COMP,
		ST_LINK,
		ST_LINK2,
		ST_DONE
	} kuf_state_t;

endpackage

@@ rtl/kuf_ram.sv @@
`timescale 1ns / 1ps

module kuf_ram #(
	parameter int DEPTH = 256,
	parameter int DW    = 20
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DW-1:0]            wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DW-1:0]            rd_data
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// write-to-read bypass on same address
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data_q <= wr_data;
			end else begin
				rd_data_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/kruskal_union_find_edge_filter.sv @@
`timescale 1ns / 1ps

// Channel   Handshake        Payload
// request   start / busy     start_req, node_a, node_b, weight
// result    done (1 cycle)   accepted, tree_weight
//
// A request walks the parent chains of node_a and node_b, each step costing a find read and a
// write-back, then links the roots if they differ, with one more write when they tie on rank.
// Out-of-range nodes go straight to done.
// After reset a clearing pass over all NODE_COUNT entries runs with busy high; the same
// pass runs on every 255th start_req, when the epoch tag wraps.
// busy stays high from acceptance through the done cycle; results cannot be stalled.

module kruskal_union_find_edge_filter
	import kuf_pkg::*;
#(
	parameter int NODE_COUNT = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                start_req,
	input  logic [NODE_W-1:0]   node_a,
	input  logic [NODE_W-1:0]   node_b,
	input  logic [WEIGHT_W-1:0] weight,
	output logic                done,
	output logic                accepted,
	output logic [TOTAL_W-1:0]  tree_weight
);

	localparam int NW = $clog2(NODE_COUNT);
	localparam int DW = EPOCH_W + RANK_W + NW;
	localparam logic [NW-1:0] LAST = NW'(NODE_COUNT - 1);

	kuf_state_t state_q, state_nxt;

	logic [NODE_W-1:0]   a_q, b_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                acc_q;
	logic [EPOCH_W-1:0]  epoch_q;
	logic                pend_q;
	logic [NW-1:0]       clr_q;
	logic                side_q;
	logic [NW-1:0]       cur_q;
	logic [NW-1:0]       ra_q, rb_q;
	logic [RANK_W-1:0]   ka_q, kb_q;

	logic                rd_en, wr_en;
	logic [NW-1:0]       rd_addr, wr_addr;
	logic [DW-1:0]       wr_data, rd_data;
	logic                side_done;

	logic                ent_valid;
	logic [NW-1:0]       dp;
	logic [RANK_W-1:0]   dk;
	logic [NW-1:0]       a_idx, b_idx, origin, root_node;
	logic                in_range;
	logic [RANK_W-1:0]   kb_inc;
	logic [TOTAL_W:0]    sum;

	kuf_ram #(
		.DEPTH (NODE_COUNT),
		.DW    (DW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// stale epoch tag reads as a fresh singleton
	assign ent_valid = (rd_data[DW-1 -: EPOCH_W] == epoch_q);
	assign dp        = ent_valid ? rd_data[NW-1:0] : cur_q;
	assign dk        = ent_valid ? rd_data[NW +: RANK_W] : '0;

	assign a_idx     = NW'(a_q);
	assign b_idx     = NW'(b_q);
	assign origin    = side_q ? b_idx : a_idx;
	assign root_node = side_q ? rb_q : ra_q;
	assign in_range  = ({24'd0, a_q} < 32'(NODE_COUNT)) && ({24'd0, b_q} < 32'(NODE_COUNT));
	assign kb_inc    = (kb_q == RANK_MAX) ? kb_q : kb_q + 1'b1;
	assign sum       = {1'b0, total_q} + (TOTAL_W + 1)'(w_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		rd_en     = 1'b0;
		rd_addr   = cur_q;
		wr_en     = 1'b0;
		wr_addr   = cur_q;
		wr_data   = '0;
		side_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = (start_req && (epoch_q == EPOCH_MAX)) ? ST_CLEAR : ST_ISSUE;
				end
			end
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == LAST) begin
					state_nxt = pend_q ? ST_ISSUE : ST_IDLE;
				end
			end
			ST_ISSUE: begin
				if (!in_range) begin
					state_nxt = ST_DONE;
				end else begin
					rd_en     = 1'b1;
					rd_addr   = a_idx;
					state_nxt = ST_FIND;
				end
			end
			ST_FIND: begin
				if (dp == cur_q) begin
					if (origin == cur_q) begin
						side_done = 1'b1;
					end else begin
						rd_en     = 1'b1;
						rd_addr   = origin;
						state_nxt = ST_COMP;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = dp;
				end
			end
			ST_COMP: begin
				wr_en   = 1'b1;
				wr_addr = cur_q;
				wr_data = {epoch_q, dk, root_node};
				if (dp == root_node) begin
					side_done = 1'b1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = dp;
				end
			end
			ST_LINK: begin
				state_nxt = ST_DONE;
				if (ra_q != rb_q) begin
					wr_en = 1'b1;
					if (ka_q > kb_q) begin
						wr_addr = rb_q;
						wr_data = {epoch_q, kb_q, ra_q};
					end else begin
						wr_addr = ra_q;
						wr_data = {epoch_q, ka_q, rb_q};
						if (ka_q == kb_q) begin
							state_nxt = ST_LINK2;
						end
					end
				end
			end
			ST_LINK2: begin
				wr_en     = 1'b1;
				wr_addr   = rb_q;
				wr_data   = {epoch_q, kb_inc, rb_q};
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
		if (side_done) begin
			if (!side_q) begin
				rd_en     = 1'b1;
				rd_addr   = b_idx;
				state_nxt = ST_FIND;
			end else begin
				state_nxt = ST_LINK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q <= '0;
			pend_q  <= 1'b0;
			clr_q   <= '0;
			side_q  <= 1'b0;
			acc_q   <= 1'b0;
			total_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start && start_req) begin
						total_q <= '0;
						if (epoch_q == EPOCH_MAX) begin
							pend_q <= 1'b1;
						end else begin
							epoch_q <= epoch_q + 1'b1;
						end
					end
				end
				ST_CLEAR: begin
					if (clr_q == LAST) begin
						clr_q   <= '0;
						epoch_q <= EPOCH_ONE;
						pend_q  <= 1'b0;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_ISSUE: begin
					acc_q  <= 1'b0;
					side_q <= 1'b0;
				end
				ST_FIND, ST_COMP: begin
					if (side_done) begin
						side_q <= 1'b1;
					end
				end
				ST_LINK: begin
					if (ra_q != rb_q) begin
						acc_q   <= 1'b1;
						total_q <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
					end
				end
				ST_LINK2, ST_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			a_q <= node_a;
			b_q <= node_b;
			w_q <= weight;
		end
		if (rd_en) begin
			cur_q <= rd_addr;
		end
		if (state_q == ST_FIND && dp == cur_q) begin
			if (side_q) begin
				rb_q <= cur_q;
				kb_q <= dk;
			end else begin
				ra_q <= cur_q;
				ka_q <= dk;
			end
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_DONE);
	assign accepted    = acc_q;
	assign tree_weight = total_q;

`ifndef SYNTH
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_epoch_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CLEAR) |-> (epoch_q != '0))
		else $error("epoch tag zero outside clearing pass");

	a_acc_from_link: assert property (@(posedge clk) disable iff (!arst_n)
		(done && accepted) |-> ($past(state_q == ST_LINK) || $past(state_q == ST_LINK2)))
		else $error("accepted result not preceded by link");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken without going busy");
`endif

endmodule
